// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// Each macro checks a property clocked on the given clock and ignored while
// the given active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, ck, rstn, ante, cons)

`define ASSERT_NEXT(lbl, ck, rstn, ante, cons)

`endif

`endif

// ===== design/gbts_pkg.sv =====
// ---------------------------------------------------------------------------
// gbts_pkg
// Types and codes shared by the gap buffer text store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbts_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MOVE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_value;
    logic [POS_W-1:0]  position;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CHAR_W-1:0]   char_out;
    logic [POS_W-1:0]    text_length;
    logic [POS_W-1:0]    cursor;
  } out_word_t;

endpackage

// ===== design/gbts_mem.sv =====
// ---------------------------------------------------------------------------
// gbts_mem
// Byte store with one write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbts_mem #(
  parameter int unsigned DEPTH = gbts_pkg::CAPACITY_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [gbts_pkg::CHAR_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [gbts_pkg::CHAR_W-1:0] rdata
);

  logic [gbts_pkg::CHAR_W-1:0] store_mem [DEPTH];
  logic [gbts_pkg::CHAR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= store_mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/gbts_ctrl.sv =====
// ---------------------------------------------------------------------------
// gbts_ctrl
// Sequencer for the gap buffer: runs inserts, reads and byte-by-byte cursor
// moves against the byte store and holds the result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbts_ctrl #(
  parameter int unsigned CAPACITY = gbts_pkg::CAPACITY_DEF,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  gbts_pkg::in_word_t          in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output gbts_pkg::out_word_t         out_word,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [gbts_pkg::CHAR_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  logic [gbts_pkg::CHAR_W-1:0] mem_rdata
);

  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (PW > gbts_pkg::POS_W) ? PW : gbts_pkg::POS_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_MOVE = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  gbts_pkg::in_word_t            item_r, item_nxt;
  logic [PW-1:0]                 gs_r, gs_nxt;
  logic [PW-1:0]                 ge_r, ge_nxt;
  logic [gbts_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                          left_r, left_nxt;
  logic [PW-1:0]                 rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]                 wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]                 rd_left_r, rd_left_nxt;
  logic                          wr_pend_r, wr_pend_nxt;
  logic                          out_valid_r, out_valid_nxt;
  gbts_pkg::out_word_t           out_word_r, out_word_nxt;

  logic [PW-1:0] gap;
  logic [PW-1:0] len;
  logic [CW-1:0] pos_cw;
  logic [CW-1:0] len_cw;
  logic [CW-1:0] gs_cw;
  logic [PW-1:0] tgt;
  logic [PW-1:0] rd_idx;
  logic          out_free;
  logic          accept;

  assign gap      = ge_r - gs_r;
  assign len      = PW'(CAPACITY) - gap;
  assign pos_cw   = CW'(item_r.position);
  assign len_cw   = CW'(len);
  assign gs_cw    = CW'(gs_r);
  assign tgt      = (pos_cw > len_cw) ? len : PW'(pos_cw);
  assign rd_idx   = (pos_cw < gs_cw) ? PW'(pos_cw) : PW'(pos_cw) + gap;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) || ((state_r == ST_RESP) && out_free));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    gs_nxt        = gs_r;
    ge_nxt        = ge_r;
    status_nxt    = status_r;
    left_nxt      = left_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_left_nxt   = rd_left_r;
    wr_pend_nxt   = wr_pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    mem_we        = 1'b0;
    mem_waddr     = wr_ptr_r[AW-1:0];
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = rd_ptr_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt  = in_word;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        status_nxt = gbts_pkg::STATUS_OK;
        state_nxt  = ST_RESP;
        unique case (item_r.func)
          gbts_pkg::FUNC_INSERT: begin
            if (gs_r == ge_r) begin
              status_nxt = gbts_pkg::STATUS_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = gs_r[AW-1:0];
              mem_wdata = item_r.char_value;
              gs_nxt    = gs_r + PW'(1);
            end
          end
          gbts_pkg::FUNC_MOVE: begin
            if (tgt < gs_r) begin
              left_nxt    = 1'b1;
              rd_ptr_nxt  = gs_r - PW'(1);
              wr_ptr_nxt  = ge_r - PW'(1);
              rd_left_nxt = gs_r - tgt;
              wr_pend_nxt = 1'b0;
              ge_nxt      = ge_r - (gs_r - tgt);
              gs_nxt      = tgt;
              state_nxt   = ST_MOVE;
            end else if (tgt > gs_r) begin
              left_nxt    = 1'b0;
              rd_ptr_nxt  = ge_r;
              wr_ptr_nxt  = gs_r;
              rd_left_nxt = tgt - gs_r;
              wr_pend_nxt = 1'b0;
              ge_nxt      = ge_r + (tgt - gs_r);
              gs_nxt      = tgt;
              state_nxt   = ST_MOVE;
            end
          end
          gbts_pkg::FUNC_READ: begin
            if (pos_cw >= len_cw) begin
              status_nxt = gbts_pkg::STATUS_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = rd_idx[AW-1:0];
            end
          end
          default: begin
          end
        endcase
      end

      ST_MOVE: begin
        if (wr_pend_r) begin
          mem_we     = 1'b1;
          wr_ptr_nxt = left_r ? wr_ptr_r - PW'(1) : wr_ptr_r + PW'(1);
        end
        if (rd_left_r != '0) begin
          mem_re      = 1'b1;
          rd_ptr_nxt  = left_r ? rd_ptr_r - PW'(1) : rd_ptr_r + PW'(1);
          rd_left_nxt = rd_left_r - PW'(1);
          wr_pend_nxt = 1'b1;
        end else begin
          wr_pend_nxt = 1'b0;
          state_nxt   = ST_RESP;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.status      = status_r;
          out_word_nxt.char_out    = ((item_r.func == gbts_pkg::FUNC_READ) &&
                                      (status_r == gbts_pkg::STATUS_OK)) ? mem_rdata : '0;
          out_word_nxt.text_length = len_cw[gbts_pkg::POS_W-1:0];
          out_word_nxt.cursor      = gs_cw[gbts_pkg::POS_W-1:0];
          state_nxt                = ST_IDLE;
          if (accept) begin
            item_nxt  = in_word;
            state_nxt = ST_EXEC;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gs_r        <= '0;
      ge_r        <= PW'(CAPACITY);
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gs_r        <= gs_nxt;
      ge_r        <= ge_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    status_r   <= status_nxt;
    left_r     <= left_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    rd_left_r  <= rd_left_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== design/gap_buffer_text_store.sv =====
// ---------------------------------------------------------------------------
// gap_buffer_text_store
// Fixed-capacity gap buffer holding text bytes in one synchronous memory.
// ---------------------------------------------------------------------------
// Usage: each input word carries an operation (insert a byte at the cursor,
// move the cursor, or read the byte at a logical index), and every accepted
// word yields exactly one result word with status, byte read, text length
// and cursor. Both channels use valid and stall; a word moves on a rising
// edge with valid high and stall low.
// Insert, read and unused operations pass through the execute and response
// states, and the result word is registered on leaving the response state.
// A cursor move over n bytes copies one byte per cycle through the memory's
// single read and write ports; a move to the current cursor skips the copy.
// Only one word is worked on at a time; the next one is taken while the
// result of the previous one waits in the output register.
// If the receiver stalls, the result is held and the block finishes at most
// one further word before it stalls its own input.
// Reset empties the text and puts the cursor at zero at once; the byte store
// is not cleared, since only written bytes are ever read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gap_buffer_text_store #(
  parameter int unsigned CAPACITY = gbts_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gbts_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output gbts_pkg::out_word_t out_word
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = gbts_pkg::POS_W;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [gbts_pkg::CHAR_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [gbts_pkg::CHAR_W-1:0] mem_rdata;
  logic                        out_full;

  gbts_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  gbts_mem #(
    .DEPTH(CAPACITY)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign out_full = out_valid && (out_word.status == gbts_pkg::STATUS_FULL);

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `ASSERT_IMPLIES(a_no_same_entry, clk, rst_n, mem_we && mem_re, mem_waddr != mem_raddr)
  `ASSERT_IMPLIES(a_full_length, clk, rst_n, out_full, out_word.text_length == LW'(CAPACITY))

endmodule
